// File: src/msll_pkg.sv
package msll_pkg;

  localparam int MAX_STATES_DEF = 16;
  localparam int COUNT_BITS_DEF = 8;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_SOLVE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_STATES = 2'd0,
    REG_ITERS  = 2'd1,
    REG_TIE    = 2'd2
  } reg_index_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic row_clear;    // start a row sum
    logic sum_step;     // add count[i][j] into the row sum
    logic div_start;    // start the divider for P[i][j]
    logic p_write;      // write the probability entry
    logic vec_init;     // load the start vector
    logic mac_clear;    // clear accumulator
    logic mac_step;     // add v[j]*P[j][i]
    logic mac_store;    // store next[i] and compare
    logic vec_commit;   // copy next into state vector
    logic min_step;     // fold v[k] into the running minimum
    logic min_first;    // first minimum entry
  } msll_cmd_t;

  typedef struct packed {
    logic div_done;
    logic same;
  } msll_sts_t;

endpackage

// File: src/msll_if.sv
interface msll_in_if;
  import msll_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [3:0] from_state;
  logic [3:0] to_state;
  modport source (output valid, op, from_state, to_state, input ready);
  modport sink (input valid, op, from_state, to_state, output ready);
endinterface

interface msll_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  state_index;
  logic [16:0] probability;
  logic        is_least;
  logic        converged;
  logic [15:0] iterations_used;
  logic        last;
  modport source (output valid, state_index, probability, is_least, converged,
                  iterations_used, last, input ready);
  modport sink (input valid, state_index, probability, is_least, converged,
                iterations_used, last, output ready);
endinterface

interface msll_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/markov_stationary_least_likely.sv
// Channel | Dir | Beat contents
// in      | in  | op, from_state, to_state
// out     | out | state_index, probability, is_least, converged,
//         |     | iterations_used, last
// cfg     | in  | index, data (states_in_use, max_iterations, tie_tolerance)
//
// An add reads the count and writes back its saturating increment; a clear
// sweeps the whole count memory, as does the clearing pass after reset. A
// solve sums each row, runs n*n divisions for the probability entries, then
// repeats the vector-matrix product until the vector holds or the limit hits.
// Input stalls while an item is in work; results hold while out.ready is low.
module markov_stationary_least_likely #(
  parameter int MAX_STATES = msll_pkg::MAX_STATES_DEF,
  parameter int COUNT_BITS = msll_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = msll_pkg::FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst,
  msll_in_if.sink    in,
  msll_out_if.source out,
  msll_cfg_if.sink   cfg
);
  import msll_pkg::*;

  localparam int SB = $clog2(MAX_STATES);
  localparam int PW = FRAC_BITS + 1;

  logic [4:0]            states_in_use;
  logic [15:0]           max_iterations;
  logic [15:0]           tie_tolerance;
  msll_cmd_t             cmd;
  msll_sts_t             sts;
  logic                  cnt_we;
  logic [2*SB-1:0]       cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [2*SB-1:0]       cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic [SB-1:0]         row_i;
  logic [SB-1:0]         col_j;
  logic [SB-1:0]         vec_k;
  logic [2*SB-1:0]       p_raddr;
  logic [PW-1:0]         vec_val;
  logic                  least;

  // Configuration registers.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      states_in_use  <= 5'd16;
      max_iterations <= 16'd1024;
      tie_tolerance  <= 16'd1;
    end else if (cfg.valid) begin
      unique case (reg_index_t'(cfg.index))
        REG_STATES: states_in_use  <= cfg.data[4:0];
        REG_ITERS:  max_iterations <= cfg.data;
        REG_TIE:    tie_tolerance  <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  assign out.probability = 17'(vec_val);
  assign out.is_least    = least;

  msll_ctrl #(.MAX_STATES(MAX_STATES), .COUNT_BITS(COUNT_BITS)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in.valid), .in_ready(in.ready), .in_op(in.op),
    .in_from(in.from_state), .in_to(in.to_state),
    .n_cfg(states_in_use), .max_iter(max_iterations),
    .out_valid(out.valid), .out_ready(out.ready), .out_index(out.state_index),
    .out_conv(out.converged), .out_iters(out.iterations_used),
    .out_last(out.last), .cmd(cmd), .sts(sts),
    .cnt_we(cnt_we), .cnt_waddr(cnt_waddr), .cnt_wdata(cnt_wdata),
    .cnt_raddr(cnt_raddr), .cnt_rdata(cnt_rdata),
    .row_i(row_i), .col_j(col_j), .vec_k(vec_k), .p_raddr(p_raddr)
  );

  msll_datapath #(
    .MAX_STATES(MAX_STATES), .COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cnt_we(cnt_we), .cnt_waddr(cnt_waddr), .cnt_wdata(cnt_wdata),
    .cnt_raddr(cnt_raddr), .cnt_rdata(cnt_rdata),
    .row_i(row_i), .col_j(col_j), .vec_k(vec_k), .p_raddr(p_raddr),
    .tie(tie_tolerance), .vec_val(vec_val), .least(least)
  );
endmodule

// File: src/msll_ram.sv
module msll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/msll_div.sv
module msll_div #(
  parameter int NUM_BITS = 24,
  parameter int DEN_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [NUM_BITS-1:0] quo
);
  localparam int CW = $clog2(NUM_BITS + 1);

  logic [DEN_BITS:0]   rem;
  logic [NUM_BITS-1:0] q;
  logic [DEN_BITS-1:0] d;
  logic [CW-1:0]       cnt;
  logic                busy;
  logic [DEN_BITS+1:0] trial;

  assign trial = {rem, q[NUM_BITS-1]} - {2'b00, d};
  assign quo   = q;

  // Restoring division, one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        q    <= num;
        d    <= den;
        cnt  <= CW'(NUM_BITS);
      end else if (busy) begin
        if (!trial[DEN_BITS+1]) begin
          rem <= trial[DEN_BITS:0];
          q   <= {q[NUM_BITS-2:0], 1'b1};
        end else begin
          rem <= {rem[DEN_BITS-1:0], q[NUM_BITS-1]};
          q   <= {q[NUM_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: src/msll_datapath.sv
module msll_datapath #(
  parameter int MAX_STATES = 16,
  parameter int COUNT_BITS = 8,
  parameter int FRAC_BITS  = 16,
  localparam int SB = $clog2(MAX_STATES),
  localparam int PW = FRAC_BITS + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  msll_pkg::msll_cmd_t    cmd,
  output msll_pkg::msll_sts_t    sts,
  // count memory access
  input  logic                   cnt_we,
  input  logic [2*SB-1:0]        cnt_waddr,
  input  logic [COUNT_BITS-1:0]  cnt_wdata,
  input  logic [2*SB-1:0]        cnt_raddr,
  output logic [COUNT_BITS-1:0]  cnt_rdata,
  // indices from the controller
  input  logic [SB-1:0]          row_i,
  input  logic [SB-1:0]          col_j,
  input  logic [SB-1:0]          vec_k,
  input  logic [2*SB-1:0]        p_raddr,
  input  logic [15:0]            tie,
  output logic [PW-1:0]          vec_val,
  output logic                   least
);
  import msll_pkg::*;

  localparam int SUMW = COUNT_BITS + SB;
  localparam int NUMW = COUNT_BITS + FRAC_BITS;
  localparam int ACCW = 2 * PW + SB;
  localparam int TW   = (PW > 16) ? PW : 16;
  localparam logic [PW-1:0] ONE = PW'(1) << FRAC_BITS;

  logic [SUMW-1:0] row_sum;
  logic [NUMW-1:0] quo;
  logic            div_done;
  logic [PW-1:0]   p_wdata;
  logic [PW-1:0]   p_rdata;
  logic [PW-1:0]   vec   [MAX_STATES];
  logic [PW-1:0]   nxt   [MAX_STATES];
  logic [SB-1:0]   col_prev;
  logic [2*PW-1:0] prod;
  logic [ACCW-1:0] acc;
  logic [ACCW-1:0] shifted;
  logic [PW-1:0]   next_val;
  logic [PW-1:0]   minv;
  logic            same;
  logic [PW-1:0]   diff;

  msll_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_STATES * MAX_STATES)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  // Probability of count over row sum; an empty row becomes a self-loop.
  always_comb begin
    if (row_sum == '0) begin
      p_wdata = (row_i == col_j) ? ONE : '0;
    end else begin
      p_wdata = quo[PW-1:0];
    end
  end

  msll_ram #(.WIDTH(PW), .DEPTH(MAX_STATES * MAX_STATES)) u_prob (
    .clk(clk), .we(cmd.p_write), .waddr({row_i, col_j}), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  msll_div #(.NUM_BITS(NUMW), .DEN_BITS(SUMW)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .num({cnt_rdata, FRAC_BITS'(0)}), .den(row_sum),
    .done(div_done), .quo(quo)
  );

  // The probability read for column j returns while the counter shows j+1.
  assign col_prev = col_j - SB'(1);
  assign prod     = vec[col_prev] * p_rdata;

  assign shifted  = acc >> FRAC_BITS;
  assign next_val = (shifted > ACCW'(ONE)) ? ONE : shifted[PW-1:0];
  assign vec_val  = vec[vec_k];
  assign diff     = vec_val - minv;
  assign least    = (diff == '0) || (TW'(tie) > TW'(diff));
  assign sts      = '{div_done: div_done, same: same};

  // Row sum, accumulator, vectors and minimum.
  always_ff @(posedge clk) begin
    if (cmd.row_clear) begin
      row_sum <= '0;
    end else if (cmd.sum_step) begin
      row_sum <= row_sum + SUMW'(cnt_rdata);
    end
    if (cmd.mac_clear) begin
      acc <= '0;
    end else if (cmd.mac_step) begin
      acc <= acc + ACCW'(prod);
    end
    if (cmd.vec_init) begin
      same <= 1'b1;
      for (int k = 0; k < MAX_STATES; k++) begin
        vec[k] <= (k == 0) ? ONE : '0;
      end
    end
    if (cmd.mac_store) begin
      nxt[row_i] <= next_val;
      if (next_val != vec[row_i]) begin
        same <= 1'b0;
      end
    end
    if (cmd.vec_commit) begin
      same <= 1'b1;
      for (int k = 0; k < MAX_STATES; k++) begin
        vec[k] <= nxt[k];
      end
    end
    if (cmd.min_step) begin
      if (cmd.min_first || vec_val < minv) begin
        minv <= vec_val;
      end
    end
  end
endmodule

// File: src/msll_ctrl.sv
module msll_ctrl #(
  parameter int MAX_STATES = 16,
  parameter int COUNT_BITS = 8,
  localparam int SB = $clog2(MAX_STATES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_op,
  input  logic [3:0]            in_from,
  input  logic [3:0]            in_to,
  input  logic [4:0]            n_cfg,
  input  logic [15:0]           max_iter,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            out_index,
  output logic                  out_conv,
  output logic [15:0]           out_iters,
  output logic                  out_last,
  output msll_pkg::msll_cmd_t   cmd,
  input  msll_pkg::msll_sts_t   sts,
  output logic                  cnt_we,
  output logic [2*SB-1:0]       cnt_waddr,
  output logic [COUNT_BITS-1:0] cnt_wdata,
  output logic [2*SB-1:0]       cnt_raddr,
  input  logic [COUNT_BITS-1:0] cnt_rdata,
  output logic [SB-1:0]         row_i,
  output logic [SB-1:0]         col_j,
  output logic [SB-1:0]         vec_k,
  output logic [2*SB-1:0]       p_raddr
);
  import msll_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RESET_CLR, S_ADD_RD, S_ADD_WR, S_CLEAR,
    S_SUM, S_DIV_RD, S_DIV_GO, S_DIV_WAIT, S_ITER, S_COMMIT, S_MIN, S_EMIT
  } state_t;

  localparam int N_MAX = MAX_STATES;

  state_t          state;
  logic [2*SB-1:0] addr;
  logic [SB:0]     n;
  logic [SB:0]     i_cnt;
  logic [SB+1:0]   j_cnt;
  logic [SB-1:0]   add_from;
  logic [SB-1:0]   add_to;
  logic [15:0]     iters;
  logic            conv;
  logic [SB:0]     n_lim;

  // Clamp states in use to one through the maximum.
  always_comb begin
    if (n_cfg == '0) begin
      n_lim = (SB + 1)'(1);
    end else if (32'(n_cfg) > N_MAX) begin
      n_lim = (SB + 1)'(N_MAX);
    end else begin
      n_lim = (SB + 1)'(n_cfg);
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_conv  = conv;
  assign out_iters = iters;
  assign row_i     = i_cnt[SB-1:0];
  assign vec_k     = i_cnt[SB-1:0];
  assign out_index = 4'(i_cnt);
  assign out_last  = (i_cnt + 1'b1 == n);
  // An add writes the saturated increment; the clearing sweeps write zero.
  assign cnt_wdata = (state != S_ADD_WR) ? '0 :
                     (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
  assign cnt_we    = (state == S_ADD_WR) || (state == S_CLEAR) || (state == S_RESET_CLR);
  assign cnt_waddr = (state == S_ADD_WR) ? {add_from, add_to} : addr;
  assign p_raddr   = {j_cnt[SB-1:0], i_cnt[SB-1:0]};

  // Column index in use this cycle.
  always_comb begin
    col_j = j_cnt[SB-1:0];
    cnt_raddr = {row_i, col_j};
    if (state == S_ADD_RD) begin
      cnt_raddr = {add_from, add_to};
    end
  end

  // Datapath commands decoded from state and counters.
  always_comb begin
    cmd = '0;
    unique case (state)
      S_SUM: begin
        cmd.sum_step = (j_cnt != '0);
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
      end
      S_DIV_WAIT: begin
        cmd.p_write = sts.div_done;
      end
      S_ITER: begin
        // read P at j, multiply and accumulate in the next cycle
        cmd.mac_step  = (j_cnt != '0) && (j_cnt <= (SB + 2)'(n));
        cmd.mac_store = (j_cnt == (SB + 2)'(n) + (SB + 2)'(1));
      end
      S_COMMIT: begin
        cmd.vec_commit = 1'b1;
      end
      S_MIN: begin
        cmd.min_step  = 1'b1;
        cmd.min_first = (i_cnt == '0);
      end
      default: begin
      end
    endcase
    if (state == S_SUM && j_cnt == '0) begin
      cmd.row_clear = 1'b1;
    end
    if (state == S_ITER && j_cnt == '0) begin
      cmd.mac_clear = 1'b1;
    end
    if (state == S_IDLE && in_valid && in_op == OP_SOLVE) begin
      cmd.vec_init = 1'b1;
    end
    // The datapath sees the column during division through col_j.
    if (state == S_DIV_WAIT && !sts.div_done) begin
      cmd.p_write = 1'b0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RESET_CLR;
      addr      <= '0;
      out_valid <= 1'b0;
      i_cnt     <= '0;
      j_cnt     <= '0;
      iters     <= '0;
      conv      <= 1'b0;
      n         <= '0;
    end else begin
      unique case (state)
        S_RESET_CLR, S_CLEAR: begin
          addr <= addr + 1'b1;
          if (addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            add_from <= SB'(in_from);
            add_to   <= SB'(in_to);
            i_cnt    <= '0;
            j_cnt    <= '0;
            addr     <= '0;
            n        <= n_lim;
            unique case (op_t'(in_op))
              OP_ADD: begin
                if (32'(in_from) < N_MAX && 32'(in_to) < N_MAX) begin
                  state <= S_ADD_RD;
                end
              end
              OP_CLEAR: state <= S_CLEAR;
              OP_SOLVE: state <= S_SUM;
              default: begin
              end
            endcase
          end
        end
        S_ADD_RD: state <= S_ADD_WR;
        S_ADD_WR: state <= S_IDLE;
        S_SUM: begin
          // count read issued at j, data seen at j+1
          if (j_cnt == (SB + 2)'(n)) begin
            j_cnt <= '0;
            state <= S_DIV_RD;
          end else begin
            j_cnt <= j_cnt + 1'b1;
          end
        end
        S_DIV_RD: begin
          // count read for this column is issued here
          state <= S_DIV_GO;
        end
        S_DIV_GO: begin
          // cnt_rdata now holds the count; the divider latches it
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (sts.div_done) begin
            if (j_cnt + 1'b1 == (SB + 2)'(n)) begin
              j_cnt <= '0;
              if (i_cnt + 1'b1 == n) begin
                i_cnt <= '0;
                iters <= '0;
                conv  <= 1'b0;
                state <= (max_iter == '0) ? S_MIN : S_ITER;
              end else begin
                i_cnt <= i_cnt + 1'b1;
                state <= S_SUM;
              end
            end else begin
              j_cnt <= j_cnt + 1'b1;
              state <= S_DIV_RD;
            end
          end
        end
        S_ITER: begin
          if (j_cnt == (SB + 2)'(n) + (SB + 2)'(1)) begin
            j_cnt <= '0;
            if (i_cnt + 1'b1 == n) begin
              i_cnt <= '0;
              iters <= iters + 1'b1;
              state <= S_COMMIT;
            end else begin
              i_cnt <= i_cnt + 1'b1;
            end
          end else begin
            j_cnt <= j_cnt + 1'b1;
          end
        end
        S_COMMIT: begin
          if (sts.same) begin
            conv  <= 1'b1;
            state <= S_MIN;
          end else if (iters == max_iter) begin
            state <= S_MIN;
          end else begin
            state <= S_ITER;
          end
        end
        S_MIN: begin
          if (i_cnt + 1'b1 == n) begin
            i_cnt     <= '0;
            out_valid <= 1'b1;
            state     <= S_EMIT;
          end else begin
            i_cnt <= i_cnt + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            if (out_last) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end else begin
              i_cnt <= i_cnt + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
